/* rtl/fsd_pkg.sv */
// fsd_pkg: shared types and constants for the flux stream decoder
// parse phases, event kinds, cell codes, block subtypes and the divide-by-1000 reciprocal
// no dependencies
package fsd_pkg;

  // stream cell and block codes
  localparam logic [7:0] BLOCK_CODE   = 8'h0d;
  localparam logic [7:0] CODE_F2_MAX  = 8'h07;
  localparam logic [7:0] CODE_NOP1    = 8'h08;
  localparam logic [7:0] CODE_NOP2    = 8'h09;
  localparam logic [7:0] CODE_NOP3    = 8'h0a;
  localparam logic [7:0] CODE_OVL16   = 8'h0b;
  localparam logic [7:0] CODE_FLUX3   = 8'h0c;

  localparam logic [31:0] OVL16_TICKS = 32'h0001_0000;

  // block subtypes
  localparam logic [7:0] SUB_INVALID = 8'h00;
  localparam logic [7:0] SUB_INFO    = 8'h01;
  localparam logic [7:0] SUB_INDEX   = 8'h02;
  localparam logic [7:0] SUB_END     = 8'h03;
  localparam logic [7:0] SUB_TEXT    = 8'h04;
  localparam logic [7:0] SUB_EOF     = 8'h0d;

  // register reset and width
  localparam int unsigned PS_W = 20;
  localparam logic [PS_W-1:0] PS_RESET = 20'd41619;

  // x / 1000 == (x * DIV_MAGIC) >> DIV_SHIFT, exact for every 32-bit x
  localparam int unsigned DIV_SHIFT = 38;
  localparam logic [28:0] DIV_MAGIC = 29'd274877907;
  localparam int unsigned QUOT_W    = 23;
  localparam logic [31:0] QUOT_LIMIT = 32'd4294968;

  typedef enum logic [3:0] {
    PH_CODE    = 4'd0,
    PH_F3HIGH  = 4'd1,
    PH_FLOW    = 4'd2,
    PH_SKIP2   = 4'd3,
    PH_SKIP1   = 4'd4,
    PH_BSUB    = 4'd5,
    PH_BSIZELO = 4'd6,
    PH_BSIZEHI = 4'd7,
    PH_BPAY    = 4'd8,
    PH_HALT    = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    EV_FLUX    = 3'd0,
    EV_INDEX   = 3'd1,
    EV_END     = 3'd2,
    EV_INVALID = 3'd3,
    EV_SUBTYPE = 3'd4,
    EV_EOF     = 3'd5
  } event_kind_t;

  localparam logic CMD_RESTART = 1'b1;

endpackage

/* rtl/flux_stream_decoder.sv */
// A result passes the stage 1, stage 2 and output registers before it leaves on out_.
// Throughput: one input transaction per cycle while in_stall is low; after the byte parse the tick
// product and the divide-by-1000 reciprocal multiply each take one pipeline stage.
// Input is stalled only when all three result stages hold waiting transactions.
// Reset (rst_n low, synchronous) clears parse state, counters and pipeline valids and loads
// the tick period register with 41619 ps.
// flux_stream_decoder: byte parser, two multiply stages and output register
// depends on fsd_pkg
module flux_stream_decoder
  import fsd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_command,
  input  logic [7:0]           in_stream_byte,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_event_kind,
  output logic [31:0]          out_event_value,
  output logic [31:0]          out_stream_position,
  output logic [31:0]          out_flux_count,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [PS_W-1:0]      cfg_picoseconds_per_tick
);

  // parse state
  phase_t      phase_r, phase_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [7:0]  sub_r, sub_nxt;
  logic [15:0] left_r, left_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [31:0] word1_r, word1_nxt;
  logic [31:0] word2_r, word2_nxt;
  logic [PS_W-1:0] ps_r;

  // parse result
  logic        emit;
  event_kind_t emit_kind;
  logic [31:0] emit_value;

  // pipeline registers
  logic        s1_valid_r, s2_valid_r, out_valid_r;
  event_kind_t s1_kind_r, s2_kind_r, out_kind_r;
  logic [31:0] s1_value_r, s2_value_r, out_value_r;
  logic [31:0] s1_pos_r, s2_pos_r, out_pos_r;
  logic [31:0] s1_cnt_r, s2_cnt_r, out_cnt_r;

  logic        out_free, s2_free, s1_free, in_accept;
  logic [31:0] s1_prod;
  logic [60:0] s2_recip;
  logic [31:0] s2_value_sel;
  logic [15:0] size_full, left_dec;
  logic [31:0] flux_sum, word1_ins, word2_ins;

  // transaction flow: each stage moves when the next one is empty or moving
  assign out_free  = !out_valid_r || !out_stall;
  assign s2_free   = !s2_valid_r || out_free;
  assign s1_free   = !s1_valid_r || s2_free;
  assign in_stall  = !s1_free;
  assign in_accept = in_valid && s1_free;
  assign cfg_ready = 1'b1;

  // helper values for the parser
  assign size_full = {in_stream_byte, left_r[7:0]};
  assign left_dec  = left_r - 16'd1;
  assign word1_ins = word1_r | ({24'd0, in_stream_byte} << {idx_r[1:0], 3'b000});
  assign word2_ins = word2_r | ({24'd0, in_stream_byte} << {idx_r[1:0], 3'b000});

  // byte parser
  always_comb begin
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    pos_nxt    = pos_r;
    cnt_nxt    = cnt_r;
    held_nxt   = held_r;
    sub_nxt    = sub_r;
    left_nxt   = left_r;
    idx_nxt    = idx_r;
    word1_nxt  = word1_r;
    word2_nxt  = word2_r;
    emit       = 1'b0;
    emit_kind  = EV_FLUX;
    emit_value = 32'd0;
    flux_sum   = acc_r + {24'd0, in_stream_byte};
    if (in_command == CMD_RESTART) begin
      phase_nxt = PH_CODE;
      acc_nxt   = 32'd0;
      pos_nxt   = 32'd0;
      cnt_nxt   = 32'd0;
      held_nxt  = 8'd0;
      sub_nxt   = 8'd0;
      left_nxt  = 16'd0;
      idx_nxt   = 4'd0;
      word1_nxt = 32'd0;
      word2_nxt = 32'd0;
    end else begin
      unique case (phase_r)
        PH_CODE: begin
          if (in_stream_byte == BLOCK_CODE) begin
            phase_nxt = PH_BSUB;
          end else begin
            pos_nxt = pos_r + 32'd1;
            priority if (in_stream_byte <= CODE_F2_MAX) begin
              held_nxt  = in_stream_byte;
              phase_nxt = PH_FLOW;
            end else if (in_stream_byte == CODE_NOP1) begin
              phase_nxt = PH_CODE;
            end else if (in_stream_byte == CODE_NOP2) begin
              phase_nxt = PH_SKIP1;
            end else if (in_stream_byte == CODE_NOP3) begin
              phase_nxt = PH_SKIP2;
            end else if (in_stream_byte == CODE_OVL16) begin
              acc_nxt = acc_r + OVL16_TICKS;
            end else if (in_stream_byte == CODE_FLUX3) begin
              phase_nxt = PH_F3HIGH;
            end else begin
              // one-byte flux cell
              emit       = 1'b1;
              emit_kind  = EV_FLUX;
              emit_value = flux_sum;
              acc_nxt    = 32'd0;
              cnt_nxt    = cnt_r + 32'd1;
            end
          end
        end
        PH_F3HIGH: begin
          pos_nxt   = pos_r + 32'd1;
          held_nxt  = in_stream_byte;
          phase_nxt = PH_FLOW;
        end
        PH_FLOW: begin
          pos_nxt    = pos_r + 32'd1;
          phase_nxt  = PH_CODE;
          emit       = 1'b1;
          emit_kind  = EV_FLUX;
          emit_value = acc_r + {16'd0, held_r, in_stream_byte};
          acc_nxt    = 32'd0;
          cnt_nxt    = cnt_r + 32'd1;
        end
        PH_SKIP2: begin
          pos_nxt   = pos_r + 32'd1;
          phase_nxt = PH_SKIP1;
        end
        PH_SKIP1: begin
          pos_nxt   = pos_r + 32'd1;
          phase_nxt = PH_CODE;
        end
        PH_BSUB: begin
          sub_nxt   = in_stream_byte;
          phase_nxt = PH_BSIZELO;
        end
        PH_BSIZELO: begin
          left_nxt  = {8'd0, in_stream_byte};
          phase_nxt = PH_BSIZEHI;
        end
        PH_BSIZEHI: begin
          left_nxt  = size_full;
          idx_nxt   = 4'd0;
          word1_nxt = 32'd0;
          word2_nxt = 32'd0;
          priority if (sub_r == SUB_INVALID) begin
            phase_nxt = PH_HALT;
            emit      = 1'b1;
            emit_kind = EV_INVALID;
          end else if (sub_r == SUB_EOF) begin
            phase_nxt = PH_HALT;
            emit      = 1'b1;
            emit_kind = EV_EOF;
          end else if (sub_r != SUB_INFO && sub_r != SUB_INDEX &&
                       sub_r != SUB_END && sub_r != SUB_TEXT) begin
            phase_nxt  = PH_HALT;
            emit       = 1'b1;
            emit_kind  = EV_SUBTYPE;
            emit_value = {24'd0, sub_r};
          end else if (size_full == 16'd0) begin
            // empty payload: an index reports offset zero, a zero end code is silent
            phase_nxt  = PH_CODE;
            emit       = (sub_r == SUB_INDEX);
            emit_kind  = EV_INDEX;
          end else begin
            phase_nxt = PH_BPAY;
          end
        end
        PH_BPAY: begin
          if (!idx_r[3] && !idx_r[2]) begin
            word1_nxt = word1_ins;
          end else if (!idx_r[3]) begin
            word2_nxt = word2_ins;
          end
          // saturate at eight, later bytes are skipped
          if (!idx_r[3]) begin
            idx_nxt = idx_r + 4'd1;
          end
          left_nxt = left_dec;
          if (left_dec == 16'd0) begin
            phase_nxt = PH_CODE;
            if (sub_r == SUB_INDEX) begin
              emit       = 1'b1;
              emit_kind  = EV_INDEX;
              emit_value = word1_nxt;
            end else if (sub_r == SUB_END && word2_nxt != 32'd0) begin
              emit       = 1'b1;
              emit_kind  = EV_END;
              emit_value = word2_nxt;
            end
          end
        end
        PH_HALT: begin
          phase_nxt = PH_HALT;
        end
        default: begin
          phase_nxt = PH_HALT;
        end
      endcase
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CODE;
      acc_r   <= 32'd0;
      pos_r   <= 32'd0;
      cnt_r   <= 32'd0;
      held_r  <= 8'd0;
      sub_r   <= 8'd0;
      left_r  <= 16'd0;
      idx_r   <= 4'd0;
      word1_r <= 32'd0;
      word2_r <= 32'd0;
    end else if (in_accept) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
      held_r  <= held_nxt;
      sub_r   <= sub_nxt;
      left_r  <= left_nxt;
      idx_r   <= idx_nxt;
      word1_r <= word1_nxt;
      word2_r <= word2_nxt;
    end
  end

  // tick period register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r <= PS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ps_r <= cfg_picoseconds_per_tick;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_r <= in_accept && emit && (in_command != CMD_RESTART);
      end
      if (s2_free) begin
        s2_valid_r <= s1_valid_r;
      end
      if (out_free) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  // stage 1: parsed event, flux carries its tick count in the value field
  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_kind_r  <= emit_kind;
      s1_value_r <= emit_value;
      s1_pos_r   <= pos_nxt;
      s1_cnt_r   <= cnt_r;
    end
  end

  // stage 2: ticks times tick period, wrapping to 32 bits
  assign s1_prod = 32'({12'd0, s1_value_r} * {32'd0, ps_r});

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_kind_r  <= s1_kind_r;
      s2_value_r <= (s1_kind_r == EV_FLUX) ? s1_prod : s1_value_r;
      s2_pos_r   <= s1_pos_r;
      s2_cnt_r   <= s1_cnt_r;
    end
  end

  // output stage: divide by 1000 through the reciprocal multiply
  assign s2_recip     = {29'd0, s2_value_r} * {32'd0, DIV_MAGIC};
  assign s2_value_sel = (s2_kind_r == EV_FLUX) ?
                        {{(32-QUOT_W){1'b0}}, s2_recip[DIV_SHIFT +: QUOT_W]} : s2_value_r;

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_kind_r  <= s2_kind_r;
      out_value_r <= s2_value_sel;
      out_pos_r   <= s2_pos_r;
      out_cnt_r   <= s2_cnt_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_event_kind      = out_kind_r;
  assign out_event_value     = out_value_r;
  assign out_stream_position = out_pos_r;
  assign out_flux_count      = out_cnt_r;

`ifndef NO_ASSERTIONS
  // a restart clears the counters
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_command == CMD_RESTART |=> pos_r == 32'd0 && cnt_r == 32'd0 &&
      phase_r == PH_CODE)
    else $error("restart did not clear parse state");

  // halted parser stays halted until a restart
  a_halt_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_command != CMD_RESTART && phase_r == PH_HALT |=>
      phase_r == PH_HALT && !s1_valid_r)
    else $error("halted parser left halt or produced an event");

  // an emitted flux interval consumes the pending ticks
  a_flux_clears_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && emit && emit_kind == EV_FLUX && in_command != CMD_RESTART |=>
      acc_r == 32'd0 && cnt_r == $past(cnt_r) + 32'd1)
    else $error("flux interval did not clear tick sum or bump count");

  // a divided 32-bit product cannot exceed its quotient range
  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == EV_FLUX |-> out_value_r < QUOT_LIMIT)
    else $error("flux interval out of range");
`endif

endmodule
